>>> design/mftpm_pkg.sv
`timescale 1ns / 1ps
package mftpm_pkg;

	localparam int ACTION_W  = 2;
	localparam int CAPTURE_W = 16;
	localparam int PERIOD_W  = 24;
	localparam int RPM_W     = 16;
	localparam int LIMIT_W   = 8;
	localparam int SCALE_W   = 32;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_CH_W  = 2;
	localparam int QUO_CNT_W = $clog2(SCALE_W);

	localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CAPTURE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ     = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE      = 1'b1;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 8'd32;
	localparam logic [SCALE_W-1:0]  SCALE_RESET    = 32'd45000000;
	localparam logic [PERIOD_W-1:0] TIMEOUT_PERIOD = 24'hFF0000;
	localparam logic [RPM_W-1:0]    RPM_MAX        = 16'hFFFF;

	typedef struct packed {
		logic load_item;
		logic div_step;
		logic div_finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_needed;
		logic div_last;
	} dp_sts_t;

endpackage

>>> design/mftpm_ctrl.sv
`timescale 1ns / 1ps
module mftpm_ctrl
	import mftpm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.load_item  = accept;
	assign cmd.div_step   = (state_q == ST_DIV);
	assign cmd.div_finish = (state_q == ST_DIV) && sts.div_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sts.div_needed) begin
							state_q <= ST_DIV;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !out_valid_q)
		else $error("result shown while divider runs");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sts.div_needed) |=> out_valid_q)
		else $error("single cycle item gave no result");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_finish |=> (out_valid_q && state_q == ST_IDLE))
		else $error("divide finish gave no result");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.div_needed) |=> (state_q == ST_DIV && !in_ready))
		else $error("divide not started");

endmodule

>>> design/mftpm_dp.sv
`timescale 1ns / 1ps
module mftpm_dp
	import mftpm_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	input  logic [ACTION_W-1:0]  action,
	input  logic [CAPTURE_W-1:0] capture_value,
	input  logic [OUT_CH_W-1:0]  channel_index,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic [OUT_CH_W-1:0]  mux_channel,
	output logic                 measurement_done,
	output logic                 timed_out,
	output logic [PERIOD_W-1:0]  stored_period,
	output logic [RPM_W-1:0]     rpm
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W = (CH_W > OUT_CH_W) ? CH_W : OUT_CH_W;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	logic [LIMIT_W-1:0]  limit_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [LIMIT_W-1:0]  ovf_q;
	logic                synced_q;
	logic [CH_W-1:0]     cur_q;
	logic [PERIOD_W-1:0] store_q [CHANNELS];

	logic [LIMIT_W-1:0]  ovf_nx;
	logic                synced_nx;
	logic [CH_W-1:0]     cur_nx;
	logic [CH_W-1:0]     cur_adv;
	logic                wr_en;
	logic [PERIOD_W-1:0] wr_data;
	logic                done_nx;
	logic                tmo_nx;
	logic [LIMIT_W:0]    ovf_inc;
	logic [IDX_W-1:0]    rd_idx;
	logic [IDX_W-1:0]    cur_ext;
	logic                rd_in_range;
	logic [PERIOD_W-1:0] rd_period;
	logic [PERIOD_W-1:0] period_nx;

	logic [PERIOD_W-1:0] dvs_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [SCALE_W-1:0]  quo_q;
	logic [QUO_CNT_W-1:0] cnt_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                ge;
	logic [SCALE_W-1:0]  quo_nx;
	logic [RPM_W-1:0]    rpm_sat;

	assign rd_idx      = IDX_W'(channel_index);
	assign rd_in_range = (32'(channel_index) < CHANNELS);
	assign rd_period   = rd_in_range ? store_q[rd_idx[CH_W-1:0]] : '0;
	assign cur_adv     = (cur_q < CH_LAST) ? cur_q + 1'b1 : '0;
	assign ovf_inc     = {1'b0, ovf_q} + 1'b1;

	assign sts.div_needed = (action == ACT_READ) && (rd_period != '0);
	assign sts.div_last   = (cnt_q == '1);

	always_comb begin
		ovf_nx    = ovf_q;
		synced_nx = synced_q;
		cur_nx    = cur_q;
		wr_en     = 1'b0;
		wr_data   = TIMEOUT_PERIOD;
		done_nx   = 1'b0;
		tmo_nx    = 1'b0;
		period_nx = '0;
		case (action)
			ACT_OVERFLOW: begin
				if (ovf_inc > {1'b0, limit_q}) begin
					wr_en     = 1'b1;
					cur_nx    = cur_adv;
					synced_nx = 1'b0;
					ovf_nx    = '0;
					done_nx   = 1'b1;
					tmo_nx    = 1'b1;
				end else begin
					ovf_nx = ovf_inc[LIMIT_W-1:0];
				end
			end
			ACT_CAPTURE: begin
				if (synced_q) begin
					wr_en     = 1'b1;
					wr_data   = {ovf_q, capture_value};
					cur_nx    = cur_adv;
					synced_nx = 1'b0;
					ovf_nx    = '0;
					done_nx   = 1'b1;
				end else begin
					synced_nx = 1'b1;
					ovf_nx    = '0;
				end
			end
			ACT_READ: begin
				period_nx = rd_period;
			end
			ACT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign cur_ext = IDX_W'(cur_nx);

	// restoring division, one quotient bit per step
	assign trial   = {rem_q, quo_q[SCALE_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign ge      = (trial >= {1'b0, dvs_q});
	assign quo_nx  = {quo_q[SCALE_W-2:0], ge};
	assign rpm_sat = (quo_nx > SCALE_W'(RPM_MAX)) ? RPM_MAX : quo_nx[RPM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			scale_q  <= SCALE_RESET;
			ovf_q    <= '0;
			synced_q <= 1'b0;
			cur_q    <= '0;
			cnt_q    <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_OVERFLOW_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
					REG_RPM_SCALE:      scale_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.load_item) begin
				ovf_q    <= ovf_nx;
				synced_q <= synced_nx;
				cur_q    <= cur_nx;
				cnt_q    <= '0;
				if (wr_en) begin
					store_q[cur_q] <= wr_data;
				end
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mux_channel      <= cur_ext[OUT_CH_W-1:0];
			measurement_done <= done_nx;
			timed_out        <= tmo_nx;
			stored_period    <= period_nx;
			rpm              <= '0;
			dvs_q            <= rd_period;
			rem_q            <= '0;
			quo_q            <= scale_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= quo_nx;
			if (cmd.div_finish) begin
				rpm <= rpm_sat;
			end
		end
	end

endmodule

>>> design/multiplexed_fan_tach_period_meter.sv
`timescale 1ns / 1ps
// channel  | handshake             | payload
// input    | in_valid / in_ready   | action, capture_value, channel_index
// output   | out_valid / out_ready | mux_channel, measurement_done, timed_out,
//          |                       | stored_period, rpm
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// overflow, capture, unused action and reads of a zero period: result in the following cycle
// read of a nonzero period: result from the bit-serial restoring divider
// one request in flight; next request taken once the result register is free or being taken
// reset clears control, config and period store at once, no clearing pass; outputs not reset
// cfg_ready is always high
module multiplexed_fan_tach_period_meter
	import mftpm_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ACTION_W-1:0]  action,
	input  logic [CAPTURE_W-1:0] capture_value,
	input  logic [OUT_CH_W-1:0]  channel_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_CH_W-1:0]  mux_channel,
	output logic                 measurement_done,
	output logic                 timed_out,
	output logic [PERIOD_W-1:0]  stored_period,
	output logic [RPM_W-1:0]     rpm
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	mftpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mftpm_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.capture_value    (capture_value),
		.channel_index    (channel_index),
		.cmd              (cmd),
		.sts              (sts),
		.mux_channel      (mux_channel),
		.measurement_done (measurement_done),
		.timed_out        (timed_out),
		.stored_period    (stored_period),
		.rpm              (rpm)
	);

endmodule

>>> verif/multiplexed_fan_tach_period_meter_tb.sv
`timescale 1ns / 1ps
module multiplexed_fan_tach_period_meter_tb;
	import mftpm_pkg::*;

	localparam int NUM_CH       = 4;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 200;

	typedef struct packed {
		logic [ACTION_W-1:0]  act;
		logic [CAPTURE_W-1:0] cap;
		logic [OUT_CH_W-1:0]  chan;
	} tach_req_t;

	typedef struct packed {
		logic [OUT_CH_W-1:0] mux;
		logic                done;
		logic                tmo;
		logic [PERIOD_W-1:0] period;
		logic [RPM_W-1:0]    rpm;
	} tach_res_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [SCALE_W-1:0]   cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action        = '0;
	logic [CAPTURE_W-1:0] capture_value = '0;
	logic [OUT_CH_W-1:0]  channel_index = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [OUT_CH_W-1:0]  mux_channel;
	logic                 measurement_done;
	logic                 timed_out;
	logic [PERIOD_W-1:0]  stored_period;
	logic [RPM_W-1:0]     rpm;

	multiplexed_fan_tach_period_meter #(.CHANNELS(NUM_CH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.capture_value(capture_value),
		.channel_index(channel_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mux_channel(mux_channel),
		.measurement_done(measurement_done),
		.timed_out(timed_out),
		.stored_period(stored_period),
		.rpm(rpm)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	tach_req_t pending_reqs[$];
	tach_res_t expected_readings[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pushed        = 0;
	int mismatches    = 0;
	int reqs_taken    = 0;
	int results_seen  = 0;
	int reads_taken   = 0;
	int timeouts_seen = 0;
	int rx_count      = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	int stall_cycles  = 0;

	// predicted meter state
	logic [LIMIT_W-1:0]  meter_limit = LIMIT_RESET;
	logic [SCALE_W-1:0]  meter_scale = SCALE_RESET;
	logic [LIMIT_W-1:0]  meter_ovf   = '0;
	logic                meter_synced = 1'b0;
	logic [OUT_CH_W-1:0] meter_chan  = '0;
	logic [PERIOD_W-1:0] meter_periods [NUM_CH] = '{default: '0};

	function automatic void store_period(input logic [PERIOD_W-1:0] p);
		meter_periods[meter_chan] = p;
		meter_chan = (meter_chan == OUT_CH_W'(NUM_CH - 1)) ? '0 : meter_chan + 1'b1;
	endfunction

	function automatic tach_res_t predict_reading(input tach_req_t r);
		tach_res_t res;
		logic [SCALE_W-1:0] quo;
		res = '0;
		case (r.act)
		ACT_OVERFLOW: begin
			if ({1'b0, meter_ovf} + 9'd1 > {1'b0, meter_limit}) begin
				store_period(TIMEOUT_PERIOD);
				meter_synced = 1'b0;
				meter_ovf = '0;
				res.done = 1'b1;
				res.tmo = 1'b1;
			end else begin
				meter_ovf = meter_ovf + 1'b1;
			end
		end
		ACT_CAPTURE: begin
			if (meter_synced) begin
				store_period({meter_ovf, r.cap});
				res.done = 1'b1;
			end
			meter_synced = !meter_synced;
			meter_ovf = '0;
		end
		ACT_READ: begin
			res.period = meter_periods[r.chan];
			if (res.period != '0) begin
				quo = meter_scale / {8'd0, res.period};
				res.rpm = (quo > {16'd0, RPM_MAX}) ? RPM_MAX : quo[RPM_W-1:0];
			end
		end
		default: ;
		endcase
		res.mux = meter_chan;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endtask

	// scoreboard
	always @(posedge clk) begin
		tach_res_t got;
		tach_res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_OVERFLOW_LIMIT)
					meter_limit = cfg_data[LIMIT_W-1:0];
				else
					meter_scale = cfg_data;
			end
			if (out_valid && out_ready) begin
				got = {mux_channel, measurement_done, timed_out, stored_period, rpm};
				results_seen++;
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: %p", got));
				end else begin
					want = expected_readings.pop_front();
					if (want.tmo)
						timeouts_seen++;
					if (got.mux !== want.mux || got.done !== want.done || got.tmo !== want.tmo
							|| got.period !== want.period || got.rpm !== want.rpm)
						report_mismatch($sformatf({"mux %0d/%0d done %0d/%0d tmo %0d/%0d ",
							"period %h/%h rpm %0d/%0d (got/exp)"}, got.mux, want.mux,
							got.done, want.done, got.tmo, want.tmo, got.period, want.period,
							got.rpm, want.rpm));
				end
			end
			if (in_valid && in_ready) begin
				expected_readings.push_back(predict_reading({action, capture_value, channel_index}));
				reqs_taken++;
				if (action == ACT_READ)
					reads_taken++;
			end
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		tach_req_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				action <= next_req.act;
				capture_value <= next_req.cap;
				channel_index <= next_req.chan;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result sink, with one long hold-off to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				rx_count <= rx_count + 1;
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && rx_count >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results outstanding",
				STALL_LIMIT, expected_readings.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_req(input logic [ACTION_W-1:0] act, input logic [CAPTURE_W-1:0] cap,
			input logic [OUT_CH_W-1:0] chan);
		pending_reqs.push_back('{act: act, cap: cap, chan: chan});
		pushed++;
	endtask

	task automatic push_overflows(input int n);
		repeat (n) push_req(ACT_OVERFLOW, 16'($urandom), 2'($urandom));
	endtask

	// sync edge, some overflows, measuring edge
	task automatic push_measurement(input int ovfs, input logic [CAPTURE_W-1:0] cap);
		push_req(ACT_CAPTURE, 16'($urandom), 2'($urandom));
		push_overflows(ovfs);
		push_req(ACT_CAPTURE, cap, 2'($urandom));
	endtask

	task automatic fill_random(input int n_items, input int limit);
		int roll;
		int target;
		int max_ovf;
		target = pushed + n_items;
		while (pushed < target) begin
			roll = $urandom_range(99);
			max_ovf = (limit < 6 || $urandom_range(9) == 0) ? limit : 5;
			if (roll < 50)
				push_measurement($urandom_range(0, max_ovf), 16'($urandom));
			else if (roll < 58 && limit <= 40)
				push_overflows(limit + 1);
			else if (roll < 80)
				push_req(ACT_READ, 16'($urandom), 2'($urandom));
			else
				push_req(2'($urandom), 16'($urandom), 2'($urandom));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained;
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_readings.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	initial begin
		int lim;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(27, 86);

		write_reg(REG_OVERFLOW_LIMIT, 32'd2);
		write_reg(REG_RPM_SCALE, '1);
		@(negedge clk);
		push_req(ACT_READ, 16'hFFFF, 2'd0);
		push_req(ACT_NONE, 16'hFFFF, 2'd3);
		push_req(ACT_CAPTURE, 16'h1234, 2'd3);
		push_overflows(2);
		push_req(ACT_CAPTURE, 16'hFFFF, 2'd0);
		push_req(ACT_READ, 16'h0000, 2'd0);
		// zero period, then period of one to saturate rpm
		push_req(ACT_CAPTURE, 16'h0000, 2'd0);
		push_req(ACT_CAPTURE, 16'h0000, 2'd0);
		push_req(ACT_CAPTURE, 16'h0001, 2'd0);
		push_req(ACT_CAPTURE, 16'h0001, 2'd0);
		// timeout while synced, then again while not synced
		push_req(ACT_CAPTURE, 16'h0000, 2'd0);
		push_overflows(3);
		push_overflows(3);
		for (int ch = 0; ch < NUM_CH; ch++)
			push_req(ACT_READ, 16'h0000, 2'(ch));
		push_req(ACT_NONE, 16'h0000, 2'd0);
		wait_drained;

		write_reg(REG_OVERFLOW_LIMIT, 32'(LIMIT_RESET));
		write_reg(REG_RPM_SCALE, SCALE_RESET);
		@(negedge clk);
		fill_random(380, 32);
		wait_drained;

		set_idle(86, 27);
		write_reg(REG_OVERFLOW_LIMIT, 32'd0);
		write_reg(REG_RPM_SCALE, 32'd1);
		@(negedge clk);
		fill_random(370, 0);
		wait_drained;

		write_reg(REG_OVERFLOW_LIMIT, 32'd255);
		write_reg(REG_RPM_SCALE, '1);
		@(negedge clk);
		push_overflows(256);
		fill_random(250, 255);
		wait_drained;

		set_idle(0, 0);
		write_reg(REG_OVERFLOW_LIMIT, 32'd1);
		write_reg(REG_RPM_SCALE, $urandom | 32'd1);
		@(negedge clk);
		fill_random(370, 1);
		wait_drained;

		lim = $urandom_range(1, 255);
		write_reg(REG_OVERFLOW_LIMIT, 32'(lim));
		write_reg(REG_RPM_SCALE, $urandom_range(1, 32'h0100_0000));
		@(negedge clk);
		fill_random(250, lim);
		wait_drained;

		$display("checked %0d requests and %0d results, %0d reads and %0d timeouts",
			reqs_taken, results_seen, reads_taken, timeouts_seen);
		$display("overflow limits 0, 1, 2, 32, 255 and %0d; scales from 1 to full range", lim);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
